/* src/rcc_pkg.sv */
// rcc_pkg: shared types, constants and helpers of the 3x3 rgb convolution
// used by the top level, rcc_front, rcc_back and the testbench; depends on nothing
`default_nettype none

package rcc_pkg;

	// parameter defaults
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int COEF_BITS_DEF  = 16;

	// queue depths (powers of two)
	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 8;

	// fixed field widths
	localparam int PIX_W     = 24;
	localparam int POS_W     = 10;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int WREG_W    = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VAL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [8:0] win_t;

	// one classified item, front to back
	typedef struct packed {
		pix_t             top;
		pix_t             mid;
		pix_t             bot;
		logic             clr;
		logic             e1;
		logic             e2;
		logic             fd;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
		logic             fd;
	} res_t;

	// result position and flags riding along the math pipeline
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
		logic             fd;
	} meta_t;

	// shift the window one column left, new column enters on the right
	function automatic win_t win_shift(win_t w, pix_t t, pix_t m, pix_t b);
		win_t n;
		n = w;
		for (int r = 0; r < 3; r++) begin
			n[r*3]   = w[r*3+1];
			n[r*3+1] = w[r*3+2];
		end
		n[2] = t;
		n[5] = m;
		n[8] = b;
		return n;
	endfunction

endpackage

`default_nettype wire

/* src/rgb_convolution_3x3_clamped.sv */
// rgb_convolution_3x3_clamped: top level, config registers, command queue
// uses rcc_pkg, rcc_front, rcc_back and rcc_fifo
//
// channel   signals                                   handshake
// cfg       cfg_write cfg_index cfg_data              write on cfg_write, no wait
// in        req_type in_red in_green in_blue          in_valid / in_ready
// out       out_red ... run_last frame_done           out_valid / out_ready
//
// one transaction in per cycle when the output keeps up; each transaction
// gives zero, one or two results, and a two-result item at a row end holds
// the command queue head until its second result issues. its path: line store
// read, command queue, window, products, sums, result queue.
// reset clears position, window and queues; line stores are not cleared.
// input and output stall independently through the command and result queues.
`default_nettype none

module rgb_convolution_3x3_clamped #(
	parameter int MAX_WIDTH  = rcc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rcc_pkg::MAX_HEIGHT_DEF,
	parameter int COEF_BITS  = rcc_pkg::COEF_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic [rcc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rcc_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          req_type,
	input  wire logic [7:0]                    in_red,
	input  wire logic [7:0]                    in_green,
	input  wire logic [7:0]                    in_blue,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         out_red,
	output logic [7:0]                         out_green,
	output logic [7:0]                         out_blue,
	output logic [rcc_pkg::POS_W-1:0]          out_row,
	output logic [rcc_pkg::POS_W-1:0]          out_col,
	output logic                               run_last,
	output logic                               frame_done
);
	import rcc_pkg::*;

	localparam int WW  = $clog2(MAX_WIDTH+1);
	localparam int HW  = $clog2(MAX_HEIGHT+1);
	localparam int CCW = $clog2(CMD_DEPTH+1);

	logic [CFG_W-1:0]  coef_top_q, coef_mid_q, coef_bot_q;
	logic [7:0]        max_value_q;
	logic [WREG_W-1:0] width_q, height_q;
	logic [WW-1:0]     eff_w;
	logic [HW-1:0]     eff_h;

	logic           cmd_push, cmd_pop, cmd_empty;
	cmd_t           cmd_in, cmd_head;
	logic [CCW-1:0] cmd_count;
	res_t           res;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q  <= '0;
			coef_mid_q  <= CFG_W'(48'd16777216);
			coef_bot_q  <= '0;
			max_value_q <= 8'd255;
			width_q     <= WREG_W'(1024);
			height_q    <= WREG_W'(1024);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_COEF_TOP: coef_top_q  <= cfg_data;
				REG_COEF_MID: coef_mid_q  <= cfg_data;
				REG_COEF_BOT: coef_bot_q  <= cfg_data;
				REG_MAX_VAL:  max_value_q <= cfg_data[7:0];
				REG_WIDTH:    width_q     <= cfg_data[WREG_W-1:0];
				REG_HEIGHT:   height_q    <= cfg_data[WREG_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size: zero acts as one, large values saturate
	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = HW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(height_q);
		end
	end

	rcc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.cmd_count (cmd_count),
		.cmd_push  (cmd_push),
		.cmd_data  (cmd_in)
	);

	// command queue between front and back
	rcc_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.count  (cmd_count),
		.empty  (cmd_empty)
	);

	rcc_back #(.COEF_BITS(COEF_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef_top  (coef_top_q),
		.coef_mid  (coef_mid_q),
		.coef_bot  (coef_bot_q),
		.max_value (max_value_q),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign out_red    = res.red;
	assign out_green  = res.green;
	assign out_blue   = res.blue;
	assign out_row    = res.row;
	assign out_col    = res.col;
	assign run_last   = res.last;
	assign frame_done = res.fd;

	// frame end is always the last result of its transaction
	a_fd_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> run_last)
		else $error("frame_done without run_last");

	// front never pushes into a full command queue
	a_cmd_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (cmd_count < CCW'(CMD_DEPTH)) || cmd_pop)
		else $error("command queue overflow");

	// an accepted transaction leaves room for the one already in flight
	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> cmd_count < CCW'(CMD_DEPTH))
		else $error("accept with full command queue");

	// never pops from an empty command queue
	a_cmd_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_empty |-> !cmd_pop)
		else $error("pop from empty command queue");

endmodule

`default_nettype wire

/* src/rcc_ram.sv */
// rcc_ram: generic one-write one-read memory with registered, read-first output
// no dependencies
`default_nettype none

module rcc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// storage and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

/* src/rcc_fifo.sv */
// rcc_fifo: small register queue with occupancy count
// no dependencies
`default_nettype none

module rcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       pop,
	output logic      [WIDTH-1:0]           rdata,
	output logic      [$clog2(DEPTH+1)-1:0] count,
	output logic                            empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign rdata = mem_q[rd_q];
	assign count = cnt_q;
	assign empty = (cnt_q == '0);

	// entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule

`default_nettype wire

/* src/rcc_front.sv */
// rcc_front: accepts transactions, tracks position, runs the two line stores
// and classifies each item into a command; uses rcc_pkg and rcc_ram
`default_nettype none

module rcc_front #(
	parameter int MAX_WIDTH  = rcc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rcc_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     eff_w,
	input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]    eff_h,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               req_type,
	input  wire logic [7:0]                         in_red,
	input  wire logic [7:0]                         in_green,
	input  wire logic [7:0]                         in_blue,
	input  wire logic [$clog2(rcc_pkg::CMD_DEPTH+1)-1:0] cmd_count,
	output logic                                    cmd_push,
	output rcc_pkg::cmd_t                           cmd_data
);
	import rcc_pkg::*;

	localparam int CAW = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH+1);
	localparam int RW  = $clog2(MAX_HEIGHT+2);
	localparam int NW  = $clog2(CMD_DEPTH+1) + 1;

	logic [RW-1:0]  in_row_q;
	logic [CAW-1:0] in_col_q;

	logic           wrap0, restart, accept, is_pix, on_frame;
	logic [RW-1:0]  row_a, r, row_inc;
	logic [CAW-1:0] c;
	logic [WW-1:0]  c_inc;
	logic           e1, e2;
	pix_t           sample;
	pix_t           rd0, rd1;

	logic              valid_s1, par_s1, has_top_s1, has_mid_s1;
	logic              clr_s1, e1_s1, e2_s1, fd_s1;
	pix_t              sample_s1;
	logic [POS_W-1:0]  row_s1, col_s1;

	// position of this item, after any wrap left by a config change
	always_comb begin
		wrap0    = WW'(in_col_q) >= eff_w;
		row_a    = wrap0 ? in_row_q + RW'(1) : in_row_q;
		restart  = row_a > RW'(eff_h);
		r        = restart ? '0 : row_a;
		c        = (wrap0 || restart) ? '0 : in_col_q;
		c_inc    = WW'(c) + WW'(1);
		row_inc  = r + RW'(1);
		on_frame = r < RW'(eff_h);
		is_pix   = !req_type && on_frame;
		sample   = is_pix ? {in_red, in_green, in_blue} : '0;
		e1       = (r != '0) && (c != '0);
		e2       = (r != '0) && (c_inc == eff_w);
	end

	// room for this item and the one in flight
	assign in_ready = (NW'(cmd_count) + NW'(valid_s1)) < NW'(CMD_DEPTH);
	assign accept   = in_valid && in_ready;

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (accept) begin
			if (c_inc >= eff_w) begin
				in_col_q <= '0;
				in_row_q <= (row_inc > RW'(eff_h)) ? '0 : row_inc;
			end else begin
				in_col_q <= c_inc[CAW-1:0];
				in_row_q <= r;
			end
		end
	end

	// line store banks, one per row parity; row r reads its own bank before overwrite
	rcc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank0 (
		.clk   (clk),
		.we    (accept && on_frame && !r[0]),
		.waddr (c),
		.wdata (sample),
		.raddr (c),
		.rdata (rd0)
	);

	rcc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank1 (
		.clk   (clk),
		.we    (accept && on_frame && r[0]),
		.waddr (c),
		.wdata (sample),
		.raddr (c),
		.rdata (rd1)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			par_s1     <= r[0];
			has_top_s1 <= r >= RW'(2);
			has_mid_s1 <= r != '0;
			sample_s1  <= sample;
			clr_s1     <= c == '0;
			e1_s1      <= e1;
			e2_s1      <= e2;
			fd_s1      <= e2 && (r == RW'(eff_h));
			row_s1     <= POS_W'(r - RW'(1));
			col_s1     <= POS_W'(c);
		end
	end

	// command out
	always_comb begin
		cmd_push     = valid_s1;
		cmd_data.top = has_top_s1 ? (par_s1 ? rd1 : rd0) : '0;
		cmd_data.mid = has_mid_s1 ? (par_s1 ? rd0 : rd1) : '0;
		cmd_data.bot = sample_s1;
		cmd_data.clr = clr_s1;
		cmd_data.e1  = e1_s1;
		cmd_data.e2  = e2_s1;
		cmd_data.fd  = fd_s1;
		cmd_data.row = row_s1;
		cmd_data.col = col_s1;
	end
endmodule

`default_nettype wire

/* src/rcc_back.sv */
// rcc_back: runs the 3x3 window, multiply-accumulate and clamp per command
// and queues results; uses rcc_pkg and rcc_fifo
`default_nettype none

module rcc_back #(
	parameter int COEF_BITS = rcc_pkg::COEF_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [rcc_pkg::CFG_W-1:0] coef_top,
	input  wire logic [rcc_pkg::CFG_W-1:0] coef_mid,
	input  wire logic [rcc_pkg::CFG_W-1:0] coef_bot,
	input  wire logic [7:0]                max_value,
	input  wire rcc_pkg::cmd_t             cmd,
	input  wire logic                      cmd_empty,
	output logic                           cmd_pop,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output rcc_pkg::res_t                  res
);
	import rcc_pkg::*;

	localparam int CXW = (3*COEF_BITS > CFG_W) ? 3*COEF_BITS : CFG_W;
	localparam int PW  = COEF_BITS + 9;
	localparam int SW  = PW + 4;
	localparam int FR  = COEF_BITS - 8;
	localparam int OCW = $clog2(OUT_DEPTH+1);
	localparam int NW  = OCW + 1;

	logic [CXW-1:0] cx [3];
	logic signed [COEF_BITS-1:0] coef [9];

	win_t  win_q;
	logic  phase_q;
	win_t  base, w1, w1z, wz, cwin, nwin;
	logic  need_out, credit, go, second, issue, empty_o;
	meta_t meta;
	logic [OCW-1:0] out_cnt;

	logic  valid_b1, valid_b2, valid_b3;
	win_t  win_b1;
	meta_t meta_b1, meta_b2, meta_b3;
	logic signed [PW-1:0] prod_b2 [3][9];
	logic signed [SW-1:0] sum_b3 [3];
	logic signed [SW-1:0] acc [3];
	logic signed [SW-1:0] q;
	logic [7:0] ch [3];
	res_t res_w;

	// coefficient fields, those past the register read as zero
	always_comb begin
		cx[0] = CXW'(coef_top);
		cx[1] = CXW'(coef_mid);
		cx[2] = CXW'(coef_bot);
		for (int k = 0; k < 9; k++) begin
			coef[k] = cx[k/3][(k%3)*COEF_BITS +: COEF_BITS];
		end
	end

	// window update and result issue
	always_comb begin
		base     = cmd.clr ? '0 : win_q;
		w1       = win_shift(base, cmd.top, cmd.mid, cmd.bot);
		w1z      = win_shift(w1, '0, '0, '0);
		wz       = win_shift(win_q, '0, '0, '0);
		need_out = phase_q || cmd.e1 || cmd.e2;
		credit   = (NW'(out_cnt) + NW'(valid_b1) + NW'(valid_b2) + NW'(valid_b3))
			< NW'(OUT_DEPTH);
		go       = !cmd_empty && (!need_out || credit);
		second   = phase_q || (!cmd.e1 && cmd.e2);
		issue    = go && need_out;
		cmd_pop  = go && (phase_q || !(cmd.e1 && cmd.e2));
		if (phase_q) begin
			cwin = wz;
			nwin = wz;
		end else if (!cmd.e1 && cmd.e2) begin
			cwin = w1z;
			nwin = w1z;
		end else begin
			cwin = w1;
			nwin = w1;
		end
		meta.row  = cmd.row;
		meta.col  = second ? cmd.col : cmd.col - POS_W'(1);
		meta.last = second || !cmd.e2;
		meta.fd   = second && cmd.fd;
	end

	// window and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			phase_q <= 1'b0;
		end else if (go) begin
			win_q   <= nwin;
			phase_q <= !phase_q && cmd.e1 && cmd.e2;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
			valid_b2 <= 1'b0;
			valid_b3 <= 1'b0;
		end else begin
			valid_b1 <= issue;
			valid_b2 <= valid_b1;
			valid_b3 <= valid_b2;
		end
	end

	// b1 window capture, b2 products, b3 sums
	always_ff @(posedge clk) begin
		win_b1  <= cwin;
		meta_b1 <= meta;
		meta_b2 <= meta_b1;
		meta_b3 <= meta_b2;
		for (int h = 0; h < 3; h++) begin
			for (int k = 0; k < 9; k++) begin
				prod_b2[h][k] <= PW'($signed({1'b0, win_b1[k][(2-h)*8 +: 8]}))
					* PW'(coef[k]);
			end
			sum_b3[h] <= acc[h];
		end
	end

	// nine-term sums
	always_comb begin
		for (int h = 0; h < 3; h++) begin
			acc[h] = '0;
			for (int k = 0; k < 9; k++) begin
				acc[h] = acc[h] + SW'(prod_b2[h][k]);
			end
		end
	end

	// floor and clamp
	always_comb begin
		q = '0;
		for (int h = 0; h < 3; h++) begin
			q = sum_b3[h] >>> FR;
			if (sum_b3[h] <= 0) begin
				ch[h] = '0;
			end else if (q > SW'(max_value)) begin
				ch[h] = max_value;
			end else begin
				ch[h] = q[7:0];
			end
		end
		res_w.red   = ch[0];
		res_w.green = ch[1];
		res_w.blue  = ch[2];
		res_w.row   = meta_b3.row;
		res_w.col   = meta_b3.col;
		res_w.last  = meta_b3.last;
		res_w.fd    = meta_b3.fd;
	end

	// result queue
	rcc_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_b3),
		.wdata  (res_w),
		.pop    (out_valid && out_ready),
		.rdata  (res),
		.count  (out_cnt),
		.empty  (empty_o)
	);

	assign out_valid = !empty_o;
endmodule

`default_nettype wire

/* tb/rgb_convolution_3x3_clamped_tb.sv */
// rgb_convolution_3x3_clamped_tb: self-checking testbench of the 3x3 rgb convolution
// holds a scoreboard class with its own filter model; uses rcc_pkg and the top level
`timescale 1ns / 100ps

module rgb_convolution_3x3_clamped_tb;
	import rcc_pkg::*;

	localparam int LINE_MAX    = 1024;
	localparam int CYCLE_LIMIT = 60000;
	localparam int SETTLE      = 16;

	// streaming 3x3 filter model and store of filtered pixels still due
	class frame_scoreboard;
		logic [23:0] line_mem [2*LINE_MAX];
		logic [23:0] taps [9];
		int unsigned row_pos, col_pos;
		logic [47:0] coef [3];
		logic [7:0]  clamp_max;
		logic [10:0] width_reg, height_reg;
		res_t        filtered_q [$];
		int          errors;

		function void clear();
			foreach (taps[k]) taps[k] = '0;
			row_pos = 0;
			col_pos = 0;
			coef[0] = '0;
			coef[1] = 48'd16777216;
			coef[2] = '0;
			clamp_max = 8'd255;
			width_reg = 11'd1024;
			height_reg = 11'd1024;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_COEF_TOP: coef[0] = val;
				REG_COEF_MID: coef[1] = val;
				REG_COEF_BOT: coef[2] = val;
				REG_MAX_VAL:  clamp_max = val[7:0];
				REG_WIDTH:    width_reg = val[10:0];
				REG_HEIGHT:   height_reg = val[10:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_w();
			if (width_reg == 0) return 1;
			if (width_reg > LINE_MAX) return LINE_MAX;
			return width_reg;
		endfunction

		function int unsigned eff_h();
			if (height_reg == 0) return 1;
			if (height_reg > LINE_MAX) return LINE_MAX;
			return height_reg;
		endfunction

		function void push_col(logic [23:0] t, logic [23:0] m, logic [23:0] b);
			for (int r = 0; r < 3; r++) begin
				taps[r*3]   = taps[r*3+1];
				taps[r*3+1] = taps[r*3+2];
			end
			taps[2] = t;
			taps[5] = m;
			taps[8] = b;
		endfunction

		// one channel: signed q8.8 dot product, floor, clamp
		function logic [7:0] filter_chan(int sh);
			longint acc;
			longint q;
			acc = 0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					acc += longint'((taps[r*3+c] >> sh) & 24'hff) *
						longint'($signed(coef[r][c*16 +: 16]));
			if (acc <= 0) return 8'd0;
			q = acc >>> 8;
			return (q > clamp_max) ? clamp_max : q[7:0];
		endfunction

		function void add_result(int unsigned r, int unsigned c, int unsigned w,
				int unsigned h);
			res_t e;
			e.red   = filter_chan(16);
			e.green = filter_chan(8);
			e.blue  = filter_chan(0);
			e.row   = r[9:0];
			e.col   = c[9:0];
			e.last  = 1'b0;
			e.fd    = (r == h - 1 && c == w - 1);
			filtered_q.push_back(e);
		endfunction

		// note one accepted input transaction
		function void note_input(logic rt, logic [7:0] red, logic [7:0] grn, logic [7:0] blu);
			int unsigned w, h, r, c, n0;
			logic [23:0] smp, top, mid;
			w = eff_w();
			h = eff_h();
			smp = '0;
			top = '0;
			mid = '0;
			n0 = filtered_q.size();
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
			if (row_pos > h) begin
				row_pos = 0;
				col_pos = 0;
			end
			r = row_pos;
			c = col_pos;
			if (!rt && r < h) smp = {red, grn, blu};
			if (r >= 2) top = line_mem[(r & 1) * LINE_MAX + c];
			if (r >= 1) mid = line_mem[((r + 1) & 1) * LINE_MAX + c];
			if (r < h) line_mem[(r & 1) * LINE_MAX + c] = smp;
			if (c == 0) foreach (taps[k]) taps[k] = '0;
			push_col(top, mid, smp);
			if (r >= 1) begin
				if (c >= 1) add_result(r - 1, c - 1, w, h);
				if (c == w - 1) begin
					push_col('0, '0, '0);
					add_result(r - 1, c, w, h);
				end
			end
			if (filtered_q.size() > n0) filtered_q[$].last = 1'b1;
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos > h) row_pos = 0;
			end
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(res_t got);
			res_t e;
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			e = filtered_q.pop_front();
			if (got.red !== e.red || got.green !== e.green || got.blue !== e.blue ||
					got.row !== e.row || got.col !== e.col || got.last !== e.last ||
					got.fd !== e.fd) begin
				$display("%0t: mismatch expected %p actual %p", $time, e, got);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid, in_ready;
	logic                 req_type;
	logic [7:0]           in_red, in_green, in_blue;
	logic                 out_valid, out_ready;
	logic [7:0]           out_red, out_green, out_blue;
	logic [POS_W-1:0]     out_row, out_col;
	logic                 run_last, frame_done;

	frame_scoreboard sb;
	int send_idle, recv_stall, hold_cycles, cycles, random_items;

	rgb_convolution_3x3_clamped uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.in_red(in_red), .in_green(in_green), .in_blue(in_blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.out_row(out_row), .out_col(out_col),
		.run_last(run_last), .frame_done(frame_done)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("rgb_convolution_3x3_clamped_tb NOT OK");
			$finish;
		end
	end

	// receiver: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// monitor both channels
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_input(req_type, in_red, in_green, in_blue);
		if (arst_n && out_valid && out_ready)
			sb.check_result({out_red, out_green, out_blue, out_row, out_col,
				run_last, frame_done});
	end

	task automatic send_pixel(logic rt, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		in_red   <= r;
		in_green <= g;
		in_blue  <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.filtered_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [7:0] rand_sample();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// coefficient row: fully random, or small taps that keep sums in range
	function automatic logic [47:0] rand_coef_row();
		logic [47:0] v;
		if ($urandom_range(3) == 0) return 48'({$urandom(), $urandom()});
		for (int k = 0; k < 3; k++)
			v[k*16 +: 16] = 16'($signed($urandom_range(640)) - 320);
		return v;
	endfunction

	// one frame plus its flush row; noise flips req_type
	task automatic send_frame(int noise_pct);
		int unsigned w, h;
		logic rt;
		w = sb.eff_w();
		h = sb.eff_h();
		for (int r = 0; r <= h; r++)
			for (int c = 0; c < w; c++) begin
				rt = (r == h);
				if ($urandom_range(99) < noise_pct) rt = ~rt;
				send_pixel(rt, rand_sample(), rand_sample(), rand_sample());
				random_items++;
			end
	endtask

	task automatic set_frame(int unsigned w, int unsigned h);
		write_reg(REG_WIDTH, CFG_W'(w));
		write_reg(REG_HEIGHT, CFG_W'(h));
	endtask

	task automatic set_idle(int phase);
		case (phase % 4)
			0: begin send_idle = 0;  recv_stall = 0;  end
			1: begin send_idle = 46; recv_stall = 0;  end
			2: begin send_idle = 0;  recv_stall = 46; end
			default: begin send_idle = 15; recv_stall = 15; end
		endcase
	endtask

	initial begin
		int phase;
		sb = new();
		sb.clear();
		cycles = 0;
		hold_cycles = 0;
		random_items = 0;
		send_idle = 0;
		recv_stall = 0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = 1'b0;
		in_red = '0;
		in_green = '0;
		in_blue = '0;
		out_ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: 3x2 frame, identity kernel, extreme samples
		set_frame(3, 2);
		send_pixel(1'b0, 8'd0, 8'd0, 8'd0);
		send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
		send_pixel(1'b0, 8'd255, 8'd0, 8'd170);
		send_pixel(1'b0, 8'd85, 8'd255, 8'd0);
		send_pixel(1'b0, 8'd1, 8'd128, 8'd254);
		send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
		repeat (3) send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
		drain();
		// early flush inside the frame and pixels during the flush row
		write_reg(REG_COEF_TOP, {16'h0100, 16'hff00, 16'h0080});
		write_reg(REG_COEF_BOT, {16'h8000, 16'h7fff, 16'h0100});
		write_reg(REG_MAX_VAL, 48'd200);
		send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
		send_pixel(1'b1, 8'd9, 8'd9, 8'd9);
		send_pixel(1'b0, 8'd255, 8'd0, 8'd255);
		send_pixel(1'b0, 8'd10, 8'd20, 8'd30);
		send_pixel(1'b0, 8'd255, 8'd255, 8'd0);
		send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
		send_pixel(1'b0, 8'd77, 8'd77, 8'd77);
		send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
		send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
		drain();

		// extremes of size, clamp and coefficients
		for (phase = 0; phase < 6; phase++) begin
			set_idle(phase);
			case (phase)
				0: begin
					write_reg(REG_MAX_VAL, 48'd0);
					set_frame(0, 3);
				end
				1: begin
					write_reg(REG_MAX_VAL, 48'd255);
					write_reg(REG_COEF_TOP, 48'h8000_8000_8000);
					write_reg(REG_COEF_MID, 48'h8000_8000_8000);
					write_reg(REG_COEF_BOT, 48'h8000_8000_8000);
					set_frame(4, 0);
				end
				2: begin
					write_reg(REG_COEF_TOP, 48'h7fff_7fff_7fff);
					write_reg(REG_COEF_MID, 48'h7fff_7fff_7fff);
					write_reg(REG_COEF_BOT, 48'h7fff_7fff_7fff);
					set_frame(5, 3);
				end
				3: begin
					write_reg(REG_COEF_TOP, 48'h0020_0020_0020);
					write_reg(REG_COEF_MID, 48'h0020_0020_0020);
					write_reg(REG_COEF_BOT, 48'h0020_0020_0020);
					set_frame(1, 5);
				end
				4: set_frame(12, 2);
				default: set_frame(3, 8);
			endcase
			send_frame(0);
			drain();
		end

		// oversized width saturates to the line length; a smaller frame then puts the
		// position in the flush row and one more item ends the frame
		set_idle(0);
		set_frame(2047, 2047);
		for (int k = 0; k < LINE_MAX + 2; k++)
			send_pixel(1'b0, rand_sample(), rand_sample(), rand_sample());
		drain();
		set_frame(3, 1);
		send_pixel(1'b0, 8'd50, 8'd60, 8'd70);
		drain();

		// random frames, mostly well formed
		random_items = 0;
		phase = 0;
		while (random_items < 700 || phase < 6) begin
			set_idle(phase);
			write_reg(REG_COEF_TOP, rand_coef_row());
			write_reg(REG_COEF_MID, rand_coef_row());
			write_reg(REG_COEF_BOT, rand_coef_row());
			write_reg(REG_MAX_VAL,
				CFG_W'(($urandom_range(3) == 0) ? $urandom_range(255) : 255));
			// long receiver hold-off on a full-size frame so the input side backs up
			if (phase == 5) begin
				set_frame(12, 6);
				hold_cycles = 400;
			end else begin
				set_frame($urandom_range(1, 12), $urandom_range(1, 6));
			end
			repeat (2) send_frame(($urandom_range(3) == 0) ? 10 : 0);
			drain();
			phase++;
		end

		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.filtered_q.size() == 0) begin
			$display("rgb_convolution_3x3_clamped_tb OK");
		end else begin
			$display("rgb_convolution_3x3_clamped_tb NOT OK");
		end
		$finish;
	end

endmodule
